// ----- hdl/pcm_sample_decode_stereo_fold_assert.svh -----
// assertion macros for the pcm sample decoder
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef PCM_SAMPLE_DECODE_STEREO_FOLD_ASSERT_SVH
`define PCM_SAMPLE_DECODE_STEREO_FOLD_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCMSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PCMSD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCMSD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PCMSD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/pcmsd_pkg.sv -----
// shared types and constants for the pcm sample decoder with stereo fold
// no dependencies
package pcmsd_pkg;

  localparam int unsigned RAW_W       = 32;
  localparam int unsigned SAMPLE_W    = 35;
  localparam int unsigned SUM_W       = SAMPLE_W + 1;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned MAX_CHANNELS = 8;

  localparam logic signed [SAMPLE_W-1:0] SAT_POS = 35'sh2_0000_0000;
  localparam logic signed [SAMPLE_W-1:0] SAT_NEG = -35'sh2_0000_0000;

  localparam logic [5:0] DEPTH_8  = 6'd8;
  localparam logic [5:0] DEPTH_16 = 6'd16;
  localparam logic [5:0] DEPTH_24 = 6'd24;
  localparam logic [5:0] DEPTH_32 = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_BITS = 3'd0,
    CFG_BIG_ENDIAN  = 3'd1,
    CFG_EIGHT_OFS   = 3'd2,
    CFG_FLOAT       = 3'd3,
    CFG_CHANNELS    = 3'd4,
    CFG_FOLD        = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]       sample_bits;
    logic             big_endian;
    logic             eight_bit_offset;
    logic             float_samples;
    logic [CNT_W-1:0] channel_count;
    logic             fold_extra;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_bits:      DEPTH_16,
    big_endian:       1'b0,
    eight_bit_offset: 1'b1,
    float_samples:    1'b0,
    channel_count:    4'd2,
    fold_extra:       1'b1
  };

endpackage

// ----- hdl/pcm_sample_decode_stereo_fold.sv -----
// pcm sample decoder with stereo fold, top level
// depends on pcmsd_pkg, pcmsd_decode and pcm_sample_decode_stereo_fold_assert.svh
//
// One raw sample is taken per clock. The sample is decoded into an input
// register in the cycle it arrives; from there it is loaded into the
// left/right frame accumulators (one 36-bit add and clamp for a channel past
// the second when fold is on) and, on the last channel of a frame, into the
// result register. Throughput is one sample per cycle;
// the input stalls only while a result waits in the result register and
// the downstream side stalls. Configuration writes are always ready and
// take effect on the next sample; write them only while the block is idle.
`include "pcm_sample_decode_stereo_fold_assert.svh"

module pcm_sample_decode_stereo_fold import pcmsd_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [RAW_W-1:0]            raw_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMPLE_W-1:0]  left_sample_o,
  output logic signed [SAMPLE_W-1:0]  right_sample_o,
  output logic                        is_stereo_o
);

  cfg_t cfg_q;

  logic                       s1_valid_q;
  logic signed [SAMPLE_W-1:0] s1_val_q;
  logic signed [SAMPLE_W-1:0] dec_val;

  logic [POS_W-1:0]           pos_q, pos_d;
  logic signed [SAMPLE_W-1:0] left_q, left_d;
  logic signed [SAMPLE_W-1:0] right_q, right_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_left_q, out_right_q;
  logic                       out_stereo_q;

  logic             blocked;
  logic             advance;
  logic             close;
  logic             stereo;
  logic [CNT_W-1:0] count;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SAMPLE_BITS: cfg_q.sample_bits      <= cfg_data_i;
        CFG_BIG_ENDIAN:  cfg_q.big_endian       <= cfg_data_i[0];
        CFG_EIGHT_OFS:   cfg_q.eight_bit_offset <= cfg_data_i[0];
        CFG_FLOAT:       cfg_q.float_samples    <= cfg_data_i[0];
        CFG_CHANNELS:    cfg_q.channel_count    <= cfg_data_i[CNT_W-1:0];
        CFG_FOLD:        cfg_q.fold_extra       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pcmsd_decode u_decode (
    .cfg_i   (cfg_q),
    .raw_i   (raw_sample_i),
    .value_o (dec_val)
  );

  assign blocked    = out_valid_q && out_stall_i;
  assign in_stall_o = s1_valid_q && blocked;
  assign advance    = s1_valid_q && !blocked;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_val_q <= dec_val;
    end
  end

  // frame accumulation
  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SAMPLE_W-1:0] acc;
    if (cfg_q.channel_count == '0) begin
      count = CNT_W'(1);
    end else if (cfg_q.channel_count > CNT_W'(MAX_CHANNELS)) begin
      count = CNT_W'(MAX_CHANNELS);
    end else begin
      count = cfg_q.channel_count;
    end
    stereo  = count >= CNT_W'(2);
    close   = ({1'b0, pos_q} + CNT_W'(1)) >= count;
    acc     = pos_q[0] ? right_q : left_q;
    sum     = SUM_W'(acc) + SUM_W'(s1_val_q);
    left_d  = left_q;
    right_d = right_q;
    if (pos_q == POS_W'(0)) begin
      left_d  = s1_val_q;
      right_d = '0;
    end else if (pos_q == POS_W'(1)) begin
      right_d = s1_val_q;
    end else if (cfg_q.fold_extra) begin
      if (sum > SUM_W'(SAT_POS)) begin
        acc = SAT_POS;
      end else if (sum < SUM_W'(SAT_NEG)) begin
        acc = SAT_NEG;
      end else begin
        acc = sum[SAMPLE_W-1:0];
      end
      if (pos_q[0]) begin
        right_d = acc;
      end else begin
        left_d = acc;
      end
    end
    pos_d       = close ? '0 : pos_q + POS_W'(1);
    out_valid_d = (advance && close) || blocked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      left_q      <= '0;
      right_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        pos_q   <= pos_d;
        left_q  <= left_d;
        right_q <= right_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance && close) begin
      out_left_q   <= left_d;
      out_right_q  <= stereo ? right_d : '0;
      out_stereo_q <= stereo;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_left_q;
  assign right_sample_o = out_right_q;
  assign is_stereo_o    = out_stereo_q;

  `PCMSD_ASSERT_IMP(a_mono_right_zero, clk_i, rst_ni, out_valid_o && !is_stereo_o, right_sample_o == '0)
  `PCMSD_ASSERT_IMP(a_out_in_range, clk_i, rst_ni, out_valid_o, left_sample_o <= SAT_POS && left_sample_o >= SAT_NEG)
  `PCMSD_ASSERT_NXT(a_frame_restart, clk_i, rst_ni, advance && close, pos_q == '0 && out_valid_q)
  `PCMSD_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q)

endmodule

// ----- hdl/pcmsd_decode.sv -----
// raw sample to fixed point (31 fractional bits), integer and ieee single
// depends on pcmsd_pkg
module pcmsd_decode import pcmsd_pkg::*; (
  input  cfg_t                        cfg_i,
  input  logic [RAW_W-1:0]            raw_i,
  output logic signed [SAMPLE_W-1:0]  value_o
);

  logic signed [SAMPLE_W-1:0] int_val;
  logic signed [SAMPLE_W-1:0] flt_val;

  // integer formats
  always_comb begin
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] u16;
    logic [23:0] u24;
    logic [31:0] u32;
    b0  = raw_i[7:0];
    b1  = raw_i[15:8];
    b2  = raw_i[23:16];
    b3  = raw_i[31:24];
    u16 = cfg_i.big_endian ? {b0, b1} : {b1, b0};
    u24 = cfg_i.big_endian ? {b0, b1, b2} : {b2, b1, b0};
    u32 = cfg_i.big_endian ? {b0, b1, b2, b3} : raw_i;
    unique case (cfg_i.sample_bits)
      DEPTH_8: begin
        if (cfg_i.eight_bit_offset) begin
          int_val = {{3{~b0[7]}}, ~b0[7], b0[6:0], 24'd0};
        end else begin
          int_val = {{3{b0[7]}}, b0, 24'd0};
        end
      end
      DEPTH_16: int_val = {{3{u16[15]}}, u16, 16'd0};
      DEPTH_24: int_val = {{3{u24[23]}}, u24, 8'd0};
      DEPTH_32: int_val = {{3{u32[31]}}, u32};
      default:  int_val = '0;
    endcase
  end

  // ieee single, round to nearest with ties away from zero
  always_comb begin
    logic        neg;
    logic [7:0]  ex;
    logic [7:0]  exp_eff;
    logic [23:0] mant;
    logic [7:0]  up_sh;
    logic [7:0]  dn_sh;
    logic [33:0] up_mag;
    logic [40:0] rnd;
    logic [33:0] mag;
    neg     = raw_i[31];
    ex      = raw_i[30:23];
    exp_eff = (ex == 8'd0) ? 8'd1 : ex;
    mant    = {(ex != 8'd0), raw_i[22:0]};
    up_sh   = exp_eff - 8'd119;
    dn_sh   = 8'd119 - exp_eff;
    up_mag  = {10'd0, mant} << up_sh[3:0];
    rnd     = {17'd0, mant} + (41'd1 << (dn_sh[5:0] - 6'd1));
    if (exp_eff >= 8'd119) begin
      if (up_sh > 8'd10 || up_mag > 34'h2_0000_0000) begin
        mag = 34'h2_0000_0000;
      end else begin
        mag = up_mag;
      end
    end else if (dn_sh > 8'd40) begin
      mag = '0;
    end else begin
      mag = 34'(rnd >> dn_sh[5:0]);
    end
    if (ex == 8'hFF) begin
      if (raw_i[22:0] != 23'd0) begin
        flt_val = '0;
      end else begin
        flt_val = neg ? SAT_NEG : SAT_POS;
      end
    end else begin
      flt_val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign value_o = (cfg_i.sample_bits == DEPTH_32 && cfg_i.float_samples) ? flt_val : int_val;

endmodule

// ----- tb/tb_pcm_sample_decode_stereo_fold.sv -----
// testbench for pcm_sample_decode_stereo_fold: random and directed raw samples
// across sample formats and channel settings, checked against a built-in frame predictor
// depends on pcmsd_pkg and the pcm_sample_decode_stereo_fold rtl
module tb_pcm_sample_decode_stereo_fold import pcmsd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint SAT_MAG = SAT_POS;
  localparam int RANDOM_PHASES = 14;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       stereo;
  } frame_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [RAW_W-1:0]           raw_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] left_sample_o;
  logic signed [SAMPLE_W-1:0] right_sample_o;
  logic                       is_stereo_o;

  logic [RAW_W-1:0] samples_to_send[$];
  frame_t           expected_frames[$];
  cfg_t             shadow_cfg = CFG_RESET;
  int unsigned      frame_pos = 0;
  longint           left_acc = 0;
  longint           right_acc = 0;
  int               err_count = 0;
  int               send_wait = 0;
  int               hold_left = 0;
  bit               no_idle = 1'b0;

  pcm_sample_decode_stereo_fold dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_sample_i   (raw_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .is_stereo_o    (is_stereo_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > SAT_MAG) return SAT_MAG;
    if (v < -SAT_MAG) return -SAT_MAG;
    return v;
  endfunction

  function automatic longint float_to_fixed(logic [RAW_W-1:0] w);
    longint unsigned m;
    longint unsigned mag;
    int              e;
    int              sh;
    m = w[22:0];
    if (w[30:23] == 8'hff) begin
      if (m != 0) return 0;
      return w[31] ? -SAT_MAG : SAT_MAG;
    end
    if (w[30:23] == 8'h00) begin
      e = 1;
    end else begin
      e = w[30:23];
      m = m | 64'h80_0000;
    end
    if (e >= 119) begin
      sh = e - 119;
      if (sh > 10) mag = SAT_MAG;
      else mag = m << sh;
      if (mag > SAT_MAG) mag = SAT_MAG;
    end else begin
      sh = 119 - e;
      if (sh > 40) mag = 0;
      else mag = (m + (64'd1 << (sh - 1))) >> sh;
    end
    return w[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint sample_value(logic [RAW_W-1:0] raw);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [15:0] v16;
    logic [23:0] v24;
    logic [31:0] v32;
    {b3, b2, b1, b0} = raw;
    case (shadow_cfg.sample_bits)
      DEPTH_8: begin
        if (shadow_cfg.eight_bit_offset) return longint'($signed({~b0[7], b0[6:0]})) <<< 24;
        return longint'($signed(b0)) <<< 24;
      end
      DEPTH_16: begin
        v16 = shadow_cfg.big_endian ? {b0, b1} : {b1, b0};
        return longint'($signed(v16)) <<< 16;
      end
      DEPTH_24: begin
        v24 = shadow_cfg.big_endian ? {b0, b1, b2} : {b2, b1, b0};
        return longint'($signed(v24)) <<< 8;
      end
      DEPTH_32: begin
        if (shadow_cfg.float_samples) return float_to_fixed(raw);
        v32 = shadow_cfg.big_endian ? {b0, b1, b2, b3} : raw;
        return longint'($signed(v32));
      end
      default: return 0;
    endcase
  endfunction

  // advance the shadow frame state by one channel sample
  function automatic void take_sample(logic [RAW_W-1:0] raw);
    longint      d;
    int unsigned chans;
    frame_t      f;
    d = sample_value(raw);
    chans = shadow_cfg.channel_count;
    if (chans == 0) chans = 1;
    if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
    if (frame_pos == 0) begin
      left_acc = d;
      right_acc = 0;
    end else if (frame_pos == 1) begin
      right_acc = d;
    end else if (shadow_cfg.fold_extra) begin
      if (frame_pos % 2) right_acc = clamp_sum(right_acc + d);
      else left_acc = clamp_sum(left_acc + d);
    end
    if (frame_pos + 1 >= chans) begin
      f.left = left_acc[SAMPLE_W-1:0];
      f.right = (chans >= 2) ? right_acc[SAMPLE_W-1:0] : '0;
      f.stereo = (chans >= 2);
      expected_frames.push_back(f);
      frame_pos = 0;
    end else begin
      frame_pos = frame_pos + 1;
    end
  endfunction

  task automatic flag_error(string what);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      raw_sample_i <= '0;
      send_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) take_sample(raw_sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          in_valid_i <= 1'b0;
          send_wait--;
        end else if (samples_to_send.size() != 0) begin
          in_valid_i <= 1'b1;
          raw_sample_i <= samples_to_send.pop_front();
          send_wait = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t f;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          flag_error($sformatf("result with nothing pending: L=%0d R=%0d S=%0b",
                               left_sample_o, right_sample_o, is_stereo_o));
        end else begin
          f = expected_frames.pop_front();
          if (f.left !== left_sample_o || f.right !== right_sample_o ||
              f.stereo !== is_stereo_o)
            flag_error($sformatf("frame mismatch: exp L=%0d R=%0d S=%0b got L=%0d R=%0d S=%0b",
                                 f.left, f.right, f.stereo,
                                 left_sample_o, right_sample_o, is_stereo_o));
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SAMPLE_BITS: shadow_cfg.sample_bits = data[5:0];
      CFG_BIG_ENDIAN:  shadow_cfg.big_endian = data[0];
      CFG_EIGHT_OFS:   shadow_cfg.eight_bit_offset = data[0];
      CFG_FLOAT:       shadow_cfg.float_samples = data[0];
      CFG_CHANNELS:    shadow_cfg.channel_count = data[CNT_W-1:0];
      CFG_FOLD:        shadow_cfg.fold_extra = data[0];
      default: ;
    endcase
  endtask

  // let every sample drain, then reprogram all registers
  task automatic set_config(cfg_t c);
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || in_valid_i || expected_frames.size() != 0);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_SAMPLE_BITS, c.sample_bits);
    write_reg(CFG_BIG_ENDIAN, {5'($urandom), c.big_endian});
    write_reg(CFG_EIGHT_OFS, {5'($urandom), c.eight_bit_offset});
    write_reg(CFG_FLOAT, {5'($urandom), c.float_samples});
    write_reg(CFG_CHANNELS, {2'($urandom), c.channel_count});
    write_reg(CFG_FOLD, {5'($urandom), c.fold_extra});
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 6'($urandom));
    cfg_valid_i <= 1'b0;
    no_idle = ($urandom_range(0, 4) == 0);
    @(negedge clk_i);
  endtask

  function automatic cfg_t mk_cfg(logic [5:0] bits, logic be, logic ofs, logic flt,
                                  logic [CNT_W-1:0] chans, logic fold);
    cfg_t c;
    c.sample_bits = bits;
    c.big_endian = be;
    c.eight_bit_offset = ofs;
    c.float_samples = flt;
    c.channel_count = chans;
    c.fold_extra = fold;
    return c;
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    logic [RAW_W-1:0] w;
    logic [7:0]       fill;
    int               pick;
    w = $urandom;
    pick = $urandom_range(0, 9);
    if (shadow_cfg.float_samples && shadow_cfg.sample_bits == DEPTH_32) begin
      if (pick < 6) w[30:23] = 8'($urandom_range(100, 140));
      else if (pick == 6) w[30:23] = 8'hff;
      else if (pick == 7) w[30:23] = 8'h00;
      else if (pick == 8) w[30:23] = 8'($urandom_range(117, 131));
    end else if (pick < 2) begin
      case ($urandom_range(0, 3))
        0: fill = 8'h00;
        1: fill = 8'h7f;
        2: fill = 8'h80;
        default: fill = 8'hff;
      endcase
      w = {4{fill}};
      w[7:0] = $urandom_range(0, 1) ? w[7:0] : 8'($urandom);
    end
    return w;
  endfunction

  initial begin
    cfg_t c;
    int   n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(mk_cfg(DEPTH_16, 1'b0, 1'b1, 1'b0, 4'd2, 1'b1));
    samples_to_send.push_back(32'h0000_8000);
    samples_to_send.push_back(32'hffff_7fff);
    set_config(mk_cfg(DEPTH_16, 1'b1, 1'b1, 1'b0, 4'd2, 1'b1));
    samples_to_send.push_back(32'h0000_0080);
    samples_to_send.push_back(32'h0000_ff7f);
    set_config(mk_cfg(DEPTH_8, 1'b0, 1'b1, 1'b0, 4'd1, 1'b1));
    samples_to_send.push_back(32'h0000_0000);
    samples_to_send.push_back(32'h1234_56ff);
    set_config(mk_cfg(DEPTH_8, 1'b1, 1'b0, 1'b0, 4'd2, 1'b0));
    samples_to_send.push_back(32'hffff_ff80);
    samples_to_send.push_back(32'h0000_007f);
    set_config(mk_cfg(DEPTH_24, 1'b1, 1'b1, 1'b0, 4'd2, 1'b1));
    samples_to_send.push_back(32'hab00_0080);
    samples_to_send.push_back(32'h00ff_ff7f);
    set_config(mk_cfg(DEPTH_32, 1'b0, 1'b1, 1'b0, 4'd3, 1'b0));
    samples_to_send.push_back(32'h8000_0000);
    samples_to_send.push_back(32'h7fff_ffff);
    samples_to_send.push_back(32'h8000_0000);
    set_config(mk_cfg(DEPTH_32, 1'b1, 1'b1, 1'b1, 4'd2, 1'b1));
    samples_to_send.push_back(32'h3f80_0000);
    samples_to_send.push_back(32'h7fc0_0000);
    samples_to_send.push_back(32'hff80_0000);
    samples_to_send.push_back(32'h0000_0001);
    samples_to_send.push_back(32'h2f80_0000);
    samples_to_send.push_back(32'h4100_0000);
    set_config(mk_cfg(DEPTH_32, 1'b0, 1'b0, 1'b1, 4'd4, 1'b1));
    samples_to_send.push_back(32'h4080_0000);
    samples_to_send.push_back(32'hc080_0000);
    samples_to_send.push_back(32'h3f00_0000);
    samples_to_send.push_back(32'hbf00_0000);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case ($urandom_range(0, 3))
        0: c.sample_bits = DEPTH_8;
        1: c.sample_bits = DEPTH_16;
        2: c.sample_bits = DEPTH_24;
        default: c.sample_bits = DEPTH_32;
      endcase
      if ($urandom_range(0, 99) < 12) c.sample_bits = 6'($urandom);
      c.big_endian = 1'($urandom);
      c.eight_bit_offset = 1'($urandom);
      c.float_samples = 1'($urandom);
      c.fold_extra = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) c.channel_count = 4'($urandom);
      else c.channel_count = 4'($urandom_range(1, 8));
      case (k)
        0: c.channel_count = 4'd1;
        1: c.channel_count = 4'd8;
        2: begin
          c.channel_count = 4'd0;
          c.sample_bits = 6'd63;
        end
        3: c.channel_count = 4'd15;
        default: ;
      endcase
      set_config(c);
      n = $urandom_range(90, 160);
      repeat (n) samples_to_send.push_back(rand_raw());
    end

    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || in_valid_i || expected_frames.size() != 0);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #12ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pcmsd_pkg.sv
hdl/pcmsd_decode.sv
hdl/pcm_sample_decode_stereo_fold.sv
tb/tb_pcm_sample_decode_stereo_fold.sv
